// ===== design/cebuf_pkg.sv =====
// cebuf_pkg: shared types and constants of the coalescing event buffer
// no dependencies; used by coalescing_event_buffer
`default_nettype none

package cebuf_pkg;

  localparam int DEPTH_DEF = 32;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_DRAIN = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         source_id;
    logic [3:0]         event_kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_source_id;
    logic [3:0]         out_event_kind;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               none_held;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  src;
    logic [3:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

`default_nettype wire

// ===== design/cebuf_ram.sv =====
// cebuf_ram: generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module cebuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/coalescing_event_buffer.sv =====
// coalescing_event_buffer: event buffer that merges repeated source id / kind pairs
// depends on cebuf_pkg and cebuf_ram
//
// input channel: in_valid_i / in_stall_o with an in_item_t payload (mode, source_id,
// event_kind, pos_x, pos_y); output channel: out_valid_o / out_stall_i with out_item_t
// one item is handled at a time; in_stall_o stays high until the item is finished
// and its last result has been taken
// push: the entry ram is scanned one entry per cycle until a match or the last held entry,
// then the matching entry is rewritten or a new one appended (dropped when the ram is full)
// drain: one result per cycle from the ram read port while out_stall_i is low, last marked;
// the first result follows the move to the drain state; an empty drain gives one marker result
// clear: drops the held count
// a stalled result holds in the ram read register and the read port waits
// reset clears the held count and all control state; ram contents are not cleared,
// entries at or beyond the held count are never read
`default_nettype none

module coalescing_event_buffer #(
  parameter int DEPTH = cebuf_pkg::DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire cebuf_pkg::in_item_t  in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output cebuf_pkg::out_item_t      out_item_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic                rd_vld_q, rd_vld_d;
  cebuf_pkg::entry_t   req_q, req_d;
  logic                out_vld_q, out_vld_d;
  logic                marker_q, marker_d;
  logic                last_q, last_d;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  cebuf_pkg::entry_t   ram_wdata, ram_rdata;

  logic                in_take, out_take, issue;
  logic                hit, at_end, full, drain_last;

  cebuf_ram #(
    .WIDTH (cebuf_pkg::EntryW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE) || out_vld_q;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_vld_q && !out_stall_i;
  assign issue      = !out_vld_q || !out_stall_i;

  assign hit    = rd_vld_q && (ram_rdata.src == req_q.src) && (ram_rdata.kind == req_q.kind);
  assign at_end = rd_vld_q ? (CW'(idx_q) == count_q - CW'(1)) : (count_q == '0);
  assign full   = (count_q == CW'(DEPTH));
  assign drain_last = (CW'(idx_q) == count_q - CW'(1));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    rd_vld_d  = rd_vld_q;
    req_d     = req_q;
    out_vld_d = out_vld_q;
    marker_d  = marker_q;
    last_d    = last_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = req_q;
    ram_re    = 1'b0;
    ram_raddr = idx_q;

    if (out_take) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_item_i.mode)
            cebuf_pkg::MODE_PUSH: begin
              req_d.src  = in_item_i.source_id;
              req_d.kind = in_item_i.event_kind;
              req_d.x    = in_item_i.pos_x;
              req_d.y    = in_item_i.pos_y;
              rd_vld_d   = 1'b0;
              state_d    = ST_SCAN;
            end
            cebuf_pkg::MODE_DRAIN: begin
              if (count_q == '0) begin
                out_vld_d = 1'b1;
                marker_d  = 1'b1;
                last_d    = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = ST_DRAIN;
              end
            end
            cebuf_pkg::MODE_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          state_d   = ST_IDLE;
        end else if (at_end) begin
          if (!full) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(count_q);
            count_d   = count_q + CW'(1);
          end
          state_d = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = rd_vld_q ? idx_q + AW'(1) : '0;
          idx_d     = ram_raddr;
          rd_vld_d  = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (issue) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q;
          out_vld_d = 1'b1;
          marker_d  = 1'b0;
          last_d    = drain_last;
          if (drain_last) begin
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      marker_q  <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      marker_q  <= marker_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign out_valid_o                = out_vld_q;
  assign out_item_o.out_source_id   = marker_q ? '0 : ram_rdata.src;
  assign out_item_o.out_event_kind  = marker_q ? '0 : ram_rdata.kind;
  assign out_item_o.out_x           = marker_q ? '0 : ram_rdata.x;
  assign out_item_o.out_y           = marker_q ? '0 : ram_rdata.y;
  assign out_item_o.none_held       = marker_q;
  assign out_item_o.last            = last_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("held count above depth");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_SCAN))
    else $error("ram write outside of push scan");

  a_read_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (CW'(ram_raddr) < count_q))
    else $error("ram read beyond held entries");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.none_held) |-> out_item_o.last)
    else $error("empty marker without last");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.last && !out_stall_i) |=> (count_q == '0))
    else $error("buffer not empty after final drain item");
`endif

endmodule

`default_nettype wire
